// File: rtl/skdc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the smoothing-kernel density and cdf block.
// No dependencies; imported by every other file of the block.
package skdc_pkg;

    localparam int IN_W  = 24;   // width of scaled_point
    localparam int WQ    = 30;   // fraction bits of the inner Q30 arithmetic
    localparam int QW    = 31;   // width that holds a Q30 value up to one
    localparam int FAM_W = 2;
    localparam int NUM_W = 48;   // width of the polynomial sums before rounding

    localparam logic [FAM_W-1:0] FAM_GAUSS = 2'd0;
    localparam logic [FAM_W-1:0] FAM_POLY6 = 2'd1;
    localparam logic [FAM_W-1:0] FAM_POLY4 = 2'd2;

    // 1/sqrt(2*pi) in Q30 and ceil(2^30/5) for the divide by five.
    localparam longint unsigned INV_SQRT_2PI = 64'd428361012;
    localparam int              RECIP5_SH    = 30;
    localparam logic [27:0]     RECIP5       = 28'd214748365;

    typedef logic [QW-1:0]           q30_t;
    typedef logic signed [NUM_W-1:0] num_t;

    // Per-item control that rides along the pipeline.
    typedef struct packed {
        logic             neg;   // input point is negative
        logic [FAM_W-1:0] fam;   // kernel family sampled at entry
        logic             gout;  // outside the Gaussian table
        logic             pout;  // outside the polynomial support
    } ctl_t;

endpackage

// File: rtl/skdc_mulq.sv
`timescale 1ns / 1ps
// Registered Q30 multiply with round to nearest, one pipeline stage.
// Depends on skdc_pkg.
module skdc_mulq import skdc_pkg::*; (
    input  logic aclk,
    input  logic en,
    input  q30_t a,
    input  q30_t b,
    output q30_t q_reg
);

    logic [2*QW-1:0] prod;
    q30_t            q_next;

    assign prod   = (2*QW)'(a) * (2*QW)'(b);
    assign q_next = QW'((prod + ((2*QW)'(1) << (WQ - 1))) >> WQ);

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

endmodule

// File: rtl/smoothing_kernel_density_and_cdf.sv
`timescale 1ns / 1ps
// Top level of the smoothing-kernel density and cdf block: the pipeline and
// the Gaussian tables. Depends on skdc_pkg and skdc_mulq.

// One standardized point enters per beat and one result leaves per beat. The
// block is a ten-stage pipeline, and with the output side ready it takes a
// new point in every cycle. Each stage holds its item until the next stage
// frees up, so a stall on m_tready fills any bubbles before s_tready drops.
// For the Gaussian family two tables (pdf and cdf, GAUSS_TABLE_DEPTH+1 Q30
// entries each over |v| in [0,8]) are read at two neighboring entries and
// interpolated. The polynomial families form u = |v|/5 and its powers through
// a chain of registered Q30 multipliers. Both outputs are clamped to [0,1] and
// rounded to OUTPUT_FRAC_BITS bits. The kernel family is written through the
// cfg channel, which is always ready; write it only while no point is in
// flight.
module smoothing_kernel_density_and_cdf import skdc_pkg::*; #(
    parameter int INPUT_FRAC_BITS   = 16,
    parameter int OUTPUT_FRAC_BITS  = 16,
    parameter int GAUSS_TABLE_DEPTH = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // [23:0] scaled_point
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // [OFB:0] density, [2*OFB+1:OFB+1] cumulative, zero fill above
    output logic [((2*(OUTPUT_FRAC_BITS+1)+7)/8)*8-1:0] m_tdata,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [FAM_W-1:0] cfg_data
);

    localparam int OW  = OUTPUT_FRAC_BITS + 1;
    localparam int MW  = ((2*OW + 7) / 8) * 8;
    localparam int FB  = INPUT_FRAC_BITS + 3;
    localparam int AW  = $clog2(GAUSS_TABLE_DEPTH + 1);
    localparam int TW  = IN_W + AW;
    localparam int NS  = 10;
    localparam int SU  = WQ - INPUT_FRAC_BITS;
    localparam longint unsigned ONE  = 64'd1 << WQ;
    localparam longint unsigned GLIM = 64'(GAUSS_TABLE_DEPTH) << FB;
    localparam longint unsigned LIM  = 64'd5 << INPUT_FRAC_BITS;
    localparam longint unsigned DEN  = 64'(3 * GAUSS_TABLE_DEPTH);
    localparam num_t NUM_ONE = num_t'(1) <<< WQ;
    localparam logic [OW-1:0] ONE_OUT = OW'(1) << OUTPUT_FRAC_BITS;

    typedef q30_t rom_t [0:GAUSS_TABLE_DEPTH];
    typedef q30_t roff_t [0:7];

    // ---------------------------------------------------------------------
    // Table construction, evaluated at elaboration.
    // ---------------------------------------------------------------------
    function automatic longint unsigned mulq_c(input longint unsigned a,
                                               input longint unsigned b);
        return (a * b + (ONE >> 1)) >> WQ;
    endfunction

    // Divides a series term by its index, each divisor a fixed number.
    function automatic longint unsigned div_idx(input longint unsigned x, input int i);
        case (i)
            2:       return x >> 1;
            3:       return x / 3;
            4:       return x >> 2;
            5:       return x / 5;
            6:       return x / 6;
            7:       return x / 7;
            8:       return x >> 3;
            9:       return x / 9;
            10:      return x / 10;
            11:      return x / 11;
            12:      return x / 12;
            13:      return x / 13;
            14:      return x / 14;
            15:      return x / 15;
            16:      return x >> 4;
            default: return x;
        endcase
    endfunction

    // e^-f for f in [0,1] by a Taylor series up to the sixteenth power of f.
    function automatic longint unsigned exp_small(input longint unsigned f);
        longint unsigned term, pos, negs;
        begin
            term = ONE;
            pos  = ONE;
            negs = 0;
            for (int i = 1; i <= 16; i++) begin
                term = div_idx(mulq_c(term, f), i);
                if (i % 2 == 1) negs += term;
                else pos += term;
            end
            return (negs > pos) ? 64'd0 : pos - negs;
        end
    endfunction

    function automatic longint unsigned exp_neg(input longint unsigned y);
        longint unsigned n, r, e1;
        begin
            n  = y >> WQ;
            r  = exp_small(y & (ONE - 1));
            e1 = exp_small(ONE);
            for (longint unsigned i = 0; i < n && r != 0; i++) begin
                r = mulq_c(r, e1);
            end
            return r;
        end
    endfunction

    function automatic longint unsigned npdf(input longint unsigned x);
        longint unsigned xs, hs;
        begin
            xs = (x + (64'd1 << 14)) >> 15;
            hs = (xs * xs + 1) >> 1;
            return mulq_c(exp_neg(hs), INV_SQRT_2PI);
        end
    endfunction

    // The cdf is one half plus a Simpson sum of the pdf, kept exact and
    // rounded once per entry.
    function automatic rom_t build_rom(input bit want_cdf);
        rom_t            tab;
        longint unsigned sum, xn, xm, pk, pn;
        begin
            sum    = 0;
            pk     = npdf(0);
            tab[0] = want_cdf ? QW'(ONE >> 1) : QW'(pk);
            for (int k = 0; k < GAUSS_TABLE_DEPTH; k++) begin
                xn  = (64'(k + 1) << (WQ + 3)) / GAUSS_TABLE_DEPTH;
                xm  = (64'(2 * k + 1) << (WQ + 2)) / GAUSS_TABLE_DEPTH;
                pn  = npdf(xn);
                sum += pk + 4 * npdf(xm) + pn;
                tab[k + 1] = want_cdf ? QW'((ONE >> 1) + (4 * sum + DEN / 2) / DEN)
                                      : QW'(pn);
                pk = pn;
            end
            return tab;
        end
    endfunction

    // Offset that the remainder of |v|/5 adds to u in Q30.
    function automatic roff_t build_roff();
        roff_t tab;
        begin
            for (int i = 0; i < 8; i++) begin
                tab[i] = QW'(((64'(i) << SU) + 2) / 5);
            end
            return tab;
        end
    endfunction

    localparam rom_t  PDF_ROM = build_rom(1'b0);
    localparam rom_t  CDF_ROM = build_rom(1'b1);
    localparam roff_t ROFF    = build_roff();

    // Clamp num / 2^(WQ+e) to [0,1] and round to the output precision.
    function automatic logic [OW-1:0] to_out(input num_t num, input int e);
        num_t full, half, c;
        int   sh;
        begin
            sh   = WQ + e - OUTPUT_FRAC_BITS;
            full = num_t'(1) <<< (WQ + e);
            half = num_t'(1) <<< (sh - 1);
            c    = num;
            if (c < 0) c = '0;
            if (c > full) c = full;
            c = c + half;
            return OW'(c >>> sh);
        end
    endfunction

    // ---------------------------------------------------------------------
    // Configuration register.
    // ---------------------------------------------------------------------
    logic [FAM_W-1:0] kernel_family_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_family_reg <= FAM_GAUSS;
        end else if (cfg_valid && cfg_ready) begin
            kernel_family_reg <= cfg_data;
        end
    end

    // ---------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or the stage after it
    // loads in the same cycle.
    // ---------------------------------------------------------------------
    logic [NS+1:1] en;
    logic [NS:1]   v_reg;
    ctl_t          ctl_reg [1:NS];

    always_comb begin
        en[NS+1] = m_tready;
        for (int k = NS; k >= 1; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[1];
    assign m_tvalid = v_reg[NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[1]) v_reg[1] <= s_tvalid;
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: sign and magnitude.
    // ---------------------------------------------------------------------
    logic [IN_W-1:0] mag1_next, mag1_reg;
    ctl_t            ctl1_next;

    always_comb begin
        ctl1_next      = '0;
        ctl1_next.neg  = s_tdata[IN_W-1];
        ctl1_next.fam  = kernel_family_reg;
        mag1_next      = s_tdata[IN_W-1] ? (~s_tdata + IN_W'(1)) : s_tdata;
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            mag1_reg <= mag1_next;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: table position and range checks, quotient of |v|/5.
    // ---------------------------------------------------------------------
    logic [TW-1:0]      t2;
    logic [IN_W+27:0]   qp2;
    logic               gout2, pout2;
    ctl_t               ctl2_next;
    logic [AW-1:0]      idx2_reg;
    logic [FB-1:0]      frac2_reg;
    logic [IN_W-1:0]    a2_reg, mag2_reg;

    assign t2    = TW'(mag1_reg) * TW'(GAUSS_TABLE_DEPTH);
    assign qp2   = (IN_W+28)'(mag1_reg) * (IN_W+28)'(RECIP5);
    assign gout2 = 64'(t2) >= GLIM;
    assign pout2 = 64'(mag1_reg) > LIM;

    always_comb begin
        ctl2_next      = ctl_reg[1];
        ctl2_next.gout = gout2;
        ctl2_next.pout = pout2;
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            idx2_reg  <= gout2 ? '0 : AW'(t2 >> FB);
            frac2_reg <= t2[FB-1:0];
            a2_reg    <= IN_W'(qp2 >> RECIP5_SH);
            mag2_reg  <= mag1_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: table reads at both neighbors, u = |v|/5 in Q30.
    // ---------------------------------------------------------------------
    logic [2:0]    r3;
    q30_t          pl3_reg, ph3_reg, cl3_reg, ch3_reg, u1_3_reg;
    logic [FB-1:0] frac3_reg;

    assign r3 = 3'(mag2_reg - a2_reg * IN_W'(5));

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            pl3_reg   <= PDF_ROM[idx2_reg];
            ph3_reg   <= PDF_ROM[idx2_reg + AW'(1)];
            cl3_reg   <= CDF_ROM[idx2_reg];
            ch3_reg   <= CDF_ROM[idx2_reg + AW'(1)];
            frac3_reg <= frac2_reg;
            u1_3_reg  <= (QW'(a2_reg) << SU) + ROFF[r3];
        end
    end

    // ---------------------------------------------------------------------
    // Stage 4: interpolation products, u^2.
    // ---------------------------------------------------------------------
    q30_t              pdiff4, cdiff4, pl4_reg, cl4_reg, u1_4_reg, u2_4;
    logic              pdn4_reg, cdn4_reg;
    logic [QW+FB-1:0]  pp4_reg, cp4_reg;

    assign pdiff4 = (ph3_reg >= pl3_reg) ? ph3_reg - pl3_reg : pl3_reg - ph3_reg;
    assign cdiff4 = (ch3_reg >= cl3_reg) ? ch3_reg - cl3_reg : cl3_reg - ch3_reg;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            pdn4_reg <= ph3_reg < pl3_reg;
            cdn4_reg <= ch3_reg < cl3_reg;
            pp4_reg  <= (QW+FB)'(pdiff4) * (QW+FB)'(frac3_reg);
            cp4_reg  <= (QW+FB)'(cdiff4) * (QW+FB)'(frac3_reg);
            pl4_reg  <= pl3_reg;
            cl4_reg  <= cl3_reg;
            u1_4_reg <= u1_3_reg;
        end
    end

    skdc_mulq u_sq2 (.aclk(aclk), .en(en[4]), .a(u1_3_reg), .b(u1_3_reg), .q_reg(u2_4));

    // ---------------------------------------------------------------------
    // Stage 5: interpolated values, u^3 and u^4.
    // ---------------------------------------------------------------------
    localparam logic [QW+FB-1:0] LHALF = (QW+FB)'(1) << (FB - 1);

    q30_t prnd5, crnd5, p5_reg, c5_reg, u1_5_reg, u2_5_reg, u3_5, u4_5;

    assign prnd5 = QW'((pp4_reg + LHALF) >> FB);
    assign crnd5 = QW'((cp4_reg + LHALF) >> FB);

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            p5_reg   <= pdn4_reg ? pl4_reg - prnd5 : pl4_reg + prnd5;
            c5_reg   <= cdn4_reg ? cl4_reg - crnd5 : cl4_reg + crnd5;
            u1_5_reg <= u1_4_reg;
            u2_5_reg <= u2_4;
        end
    end

    skdc_mulq u_pw3 (.aclk(aclk), .en(en[5]), .a(u2_4), .b(u1_4_reg), .q_reg(u3_5));
    skdc_mulq u_pw4 (.aclk(aclk), .en(en[5]), .a(u2_4), .b(u2_4), .q_reg(u4_5));

    // ---------------------------------------------------------------------
    // Stage 6: Gaussian outputs, u^5 and u^6.
    // ---------------------------------------------------------------------
    logic [OW-1:0] gd_reg [6:9];
    logic [OW-1:0] gc_reg [6:9];
    logic [OW-1:0] gd6_next, gc6_next;
    q30_t          u1_6_reg, u2_6_reg, u3_6_reg, u4_6_reg, u5_6, u6_6;

    assign gd6_next = to_out(num_t'(p5_reg), 0);
    assign gc6_next = ctl_reg[5].neg ? to_out(NUM_ONE - num_t'(c5_reg), 0)
                                     : to_out(num_t'(c5_reg), 0);

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            u1_6_reg  <= u1_5_reg;
            u2_6_reg  <= u2_5_reg;
            u3_6_reg  <= u3_5;
            u4_6_reg  <= u4_5;
        end
    end

    skdc_mulq u_pw5 (.aclk(aclk), .en(en[6]), .a(u4_5), .b(u1_5_reg), .q_reg(u5_6));
    skdc_mulq u_pw6 (.aclk(aclk), .en(en[6]), .a(u4_5), .b(u2_5_reg), .q_reg(u6_6));

    // ---------------------------------------------------------------------
    // Stage 7: u^7.
    // ---------------------------------------------------------------------
    q30_t u1_7_reg, u2_7_reg, u3_7_reg, u4_7_reg, u5_7_reg, u6_7_reg, u7_7;

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            u1_7_reg <= u1_6_reg;
            u2_7_reg <= u2_6_reg;
            u3_7_reg <= u3_6_reg;
            u4_7_reg <= u4_6_reg;
            u5_7_reg <= u5_6;
            u6_7_reg <= u6_6;
        end
    end

    skdc_mulq u_pw7 (.aclk(aclk), .en(en[7]), .a(u6_6), .b(u1_6_reg), .q_reg(u7_7));

    // ---------------------------------------------------------------------
    // Stage 8: even and odd polynomial sums.
    // ---------------------------------------------------------------------
    num_t p8_next, q8_next, p8_reg, q8_reg;

    always_comb begin
        if (ctl_reg[7].fam == FAM_POLY6) begin
            p8_next = NUM_ONE - 5 * num_t'(u2_7_reg) + 7 * num_t'(u4_7_reg)
                      - 3 * num_t'(u6_7_reg);
            q8_next = 105 * num_t'(u1_7_reg) - 175 * num_t'(u3_7_reg)
                      + 147 * num_t'(u5_7_reg) - 45 * num_t'(u7_7);
        end else begin
            p8_next = 15 * NUM_ONE - 70 * num_t'(u2_7_reg) + 63 * num_t'(u4_7_reg);
            q8_next = 225 * num_t'(u1_7_reg) - 350 * num_t'(u3_7_reg)
                      + 189 * num_t'(u5_7_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[8]) begin
            p8_reg <= p8_next;
            q8_reg <= q8_next;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 9: scaled density and cumulative numerators.
    // ---------------------------------------------------------------------
    num_t dn9_reg, cn9_reg;
    logic poly6_8;

    assign poly6_8 = ctl_reg[8].fam == FAM_POLY6;

    always_ff @(posedge aclk) begin
        if (en[9]) begin
            dn9_reg <= poly6_8 ? 21 * p8_reg : 3 * p8_reg;
            cn9_reg <= (poly6_8 ? (NUM_ONE <<< 5) : (NUM_ONE <<< 6))
                       + (ctl_reg[8].neg ? -q8_reg : q8_reg);
        end
    end

    // Control rides along every stage, and the Gaussian results along
    // stages 6 to 9.
    always_ff @(posedge aclk) begin
        if (en[1]) ctl_reg[1] <= ctl1_next;
        if (en[2]) ctl_reg[2] <= ctl2_next;
        for (int k = 3; k <= NS; k++) begin
            if (en[k]) ctl_reg[k] <= ctl_reg[k-1];
        end
        if (en[6]) begin
            gd_reg[6] <= gd6_next;
            gc_reg[6] <= gc6_next;
        end
        for (int k = 7; k <= 9; k++) begin
            if (en[k]) begin
                gd_reg[k] <= gd_reg[k-1];
                gc_reg[k] <= gc_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage 10: output register. Outside the table or the support the
    // density is zero and the cumulative value saturates by sign.
    // ---------------------------------------------------------------------
    logic [OW-1:0] dens_next, cum_next, dens_reg, cum_reg;
    logic          outside9;

    always_comb begin
        outside9 = (ctl_reg[9].fam == FAM_GAUSS) ? ctl_reg[9].gout : ctl_reg[9].pout;
        if (outside9) begin
            dens_next = '0;
            cum_next  = ctl_reg[9].neg ? '0 : ONE_OUT;
        end else if (ctl_reg[9].fam == FAM_GAUSS) begin
            dens_next = gd_reg[9];
            cum_next  = gc_reg[9];
        end else if (ctl_reg[9].fam == FAM_POLY6) begin
            dens_next = to_out(dn9_reg, 6);
            cum_next  = to_out(cn9_reg, 6);
        end else begin
            dens_next = to_out(dn9_reg, 7);
            cum_next  = to_out(cn9_reg, 7);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[NS]) begin
            dens_reg <= dens_next;
            cum_reg  <= cum_next;
        end
    end

    assign m_tdata = MW'({cum_reg, dens_reg});

endmodule

// File: rtl/skdc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the smoothing-kernel density and cdf block, bound
// to the top level. Depends on skdc_pkg.
module skdc_port_checks import skdc_pkg::*; #(
    parameter int OUTPUT_FRAC_BITS = 16
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [((2*(OUTPUT_FRAC_BITS+1)+7)/8)*8-1:0] m_tdata,
    input logic             cfg_valid,
    input logic             cfg_ready,
    input logic [FAM_W-1:0] cfg_data
);

    localparam int OW = OUTPUT_FRAC_BITS + 1;
    localparam logic [OW-1:0] ONE_OUT = OW'(1) << OUTPUT_FRAC_BITS;

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat present right after reset");

    // A held result keeps its data.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // Both outputs stay within [0,1].
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OW-1:0] <= ONE_OUT) && (m_tdata[2*OW-1:OW] <= ONE_OUT))
        else $error("output value above one");

    // The input side only stalls when the output side is stalled.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with the output free");

endmodule

bind smoothing_kernel_density_and_cdf skdc_port_checks #(
    .OUTPUT_FRAC_BITS(OUTPUT_FRAC_BITS)
) u_skdc_port_checks (.*);
